### rtl/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions for the sha-256 block
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int ROUNDS      = 64;
    localparam int QUEUE_DEPTH = 4;

    typedef logic [31:0] word_t;

    // item handed from the front to the back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } back_state_t;

    localparam word_t START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    function automatic word_t ror32(input word_t x, input int r);
        ror32 = (x >> r) | (x << (32 - r));
    endfunction

    function automatic word_t small_sig0(input word_t x);
        small_sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sig1(input word_t x);
        small_sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t big_sig0(input word_t x);
        big_sig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic word_t big_sig1(input word_t x);
        big_sig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

endpackage

### rtl/sha_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_in_if
// input channel: one message byte with its flags
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

### rtl/sha_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_out_if
// output channel: one digest word
// ----------------------------------------------------------------------------
interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;

    modport source (output valid, digest_word, word_number, last_word, input ready);
    modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface

### rtl/sha_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_front
// accepts input transfers, drops empty items, queues the rest for the core
// ----------------------------------------------------------------------------
module sha_front
    import sha_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    sha_in_if.sink     in_ch,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t            mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic            push, pop;

    assign in_ch.ready = (count_reg != (AW+1)'(DEPTH));
    assign push = in_ch.valid && in_ch.ready && (in_ch.byte_present || in_ch.end_of_message);
    assign pop  = cmd_valid && cmd_ready;
    assign cmd_valid = (count_reg != '0);
    assign cmd = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{in_ch.data_byte, in_ch.byte_present, in_ch.end_of_message};
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !pop) else $error("pop from empty queue");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("count did not follow push");
`endif
endmodule

### rtl/sha_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_back
// block words, padding, one round per cycle compression and digest output
// ----------------------------------------------------------------------------
module sha_back
    import sha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    sha_out_if.source  out_ch
);
    back_state_t  state_reg, state_next;
    word_t        hash_reg [8];
    word_t        v_reg [8];
    word_t        w_reg [16];
    logic [5:0]   fill_reg;
    logic [63:0]  msg_bytes_reg;
    logic [5:0]   round_reg;
    logic [2:0]   word_reg;
    logic         padding_reg;
    logic         pad_first_reg;
    logic         pad_wrap_reg;
    // length bytes written means the padded message is complete
    logic         len_done_reg;

    logic         take;
    logic         put;
    logic [7:0]   put_byte;
    logic [4:0]   lane_lsb;
    logic         start_comp;
    logic [63:0]  bit_len;
    logic [7:0]   pad_byte;
    word_t        tmp1, tmp2, w_new, w_cur;

    assign bit_len = {msg_bytes_reg[60:0], 3'b000};
    assign lane_lsb = {~fill_reg[1:0], 3'b000};

    always_comb
    begin
        if (pad_first_reg)
        begin
            pad_byte = PAD_BYTE;
        end
        else if (fill_reg >= LEN_OFFSET && !pad_wrap_reg)
        begin
            pad_byte = bit_len[8'(63 - 8 * 32'(fill_reg[2:0])) -: 8];
        end
        else
        begin
            pad_byte = '0;
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign take = cmd_valid && cmd_ready;

    always_comb
    begin
        put = 1'b0;
        put_byte = cmd.data_byte;
        if (state_reg == ST_IDLE && take && cmd.byte_present)
        begin
            put = 1'b1;
        end
        else if (state_reg == ST_PAD)
        begin
            put = 1'b1;
            put_byte = pad_byte;
        end
    end

    assign start_comp = put && (fill_reg == 6'd63);

    assign w_cur = w_reg[0];
    assign w_new = w_reg[0] + small_sig0(w_reg[1]) + w_reg[9] + small_sig1(w_reg[14]);
    assign tmp1  = v_reg[7] + big_sig1(v_reg[4])
                 + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
                 + ROUND_K[round_reg] + w_cur;
    assign tmp2  = big_sig0(v_reg[0])
                 + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (start_comp)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (cmd.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (start_comp)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == 6'(ROUNDS - 1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (!padding_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (fill_reg == '0 && !pad_first_reg && len_done_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                if (out_ch.ready && word_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid       = (state_reg == ST_EMIT);
    assign out_ch.digest_word = hash_reg[word_reg];
    assign out_ch.word_number = word_reg;
    assign out_ch.last_word   = (word_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            msg_bytes_reg <= '0;
            round_reg     <= '0;
            word_reg      <= '0;
            padding_reg   <= 1'b0;
            pad_first_reg <= 1'b0;
            pad_wrap_reg  <= 1'b0;
            len_done_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= START_HASH[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            if (put)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (take && cmd.byte_present)
            begin
                msg_bytes_reg <= msg_bytes_reg + 1'b1;
            end
            if (take && cmd.end_of_message)
            begin
                padding_reg   <= 1'b1;
                pad_first_reg <= 1'b1;
                len_done_reg  <= 1'b0;
            end
            if (state_reg == ST_PAD)
            begin
                pad_first_reg <= 1'b0;
                // pad byte past the length offset: length goes in the next block
                if (start_comp)
                begin
                    pad_wrap_reg <= 1'b0;
                end
                else if (pad_first_reg && fill_reg >= LEN_OFFSET)
                begin
                    pad_wrap_reg <= 1'b1;
                end
                if (fill_reg == 6'd63 && !pad_first_reg && !pad_wrap_reg)
                begin
                    len_done_reg <= 1'b1;
                end
            end
            if (state_reg == ST_ROUND)
            begin
                round_reg <= round_reg + 1'b1;
            end
            if (state_reg == ST_ADD)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
                end
            end
            if (state_reg == ST_EMIT && out_ch.ready)
            begin
                word_reg <= word_reg + 1'b1;
                if (word_reg == 3'd7)
                begin
                    padding_reg   <= 1'b0;
                    len_done_reg  <= 1'b0;
                    msg_bytes_reg <= '0;
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= START_HASH[i];
                    end
                end
            end
        end
    end

    // bytes land in the schedule window, which is idle while bytes arrive
    always_ff @(posedge clk)
    begin
        if (put)
        begin
            w_reg[fill_reg[5:2]][lane_lsb +: 8] <= put_byte;
            if (start_comp)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= hash_reg[i];
                end
            end
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int t = 0; t < 15; t++)
            begin
                w_reg[t] <= w_reg[t+1];
            end
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + tmp1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= tmp1 + tmp2;
        end
    end

`ifndef NO_ASSERTIONS
    a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ROUND && state_next == ST_ROUND) |-> (round_reg == '0))
        else $error("round counter not at zero on start");
    a_emit_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (fill_reg == '0 && padding_reg))
        else $error("digest out with partial block");
    a_word_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_ch.ready && word_reg == 3'd7) |=> (state_reg == ST_IDLE))
        else $error("emit did not end after last word");
`endif
endmodule

### rtl/sha256_hash_top.sv
`timescale 1ns / 1ps
// a byte that fills a block starts a compression (the rounds, then the add) before
// the next item is taken; end of message adds padding at one byte per cycle,
// one or two compressions and eight output transfers
// throughput: one byte per cycle while the block buffer fills
// reset: rst_n async low, loads the initial hash values and empties the queue
// ----------------------------------------------------------------------------
// sha256_hash_top
// sha-256 digest of a byte stream, front queue and compression back end
// ----------------------------------------------------------------------------
module sha256_hash_top
    import sha_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    sha_front #(.DEPTH(QDEPTH)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    sha_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_ch    (out_ch)
    );
endmodule
